### rtl/core/smtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smtq_pkg
// Shared types, codes and helpers of the sorted multi-timer queue core.
// ----------------------------------------------------------------------------
package smtq_pkg;

    // field widths
    localparam int IDW = 3;
    localparam int DLW = 64;
    localparam int IVW = 32;
    localparam int PRW = 8;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // result status codes
    localparam logic [2:0] STS_STARTED = 3'd0;
    localparam logic [2:0] STS_REFUSED = 3'd1;
    localparam logic [2:0] STS_BAD_ID  = 3'd2;
    localparam logic [2:0] STS_STOPPED = 3'd3;
    localparam logic [2:0] STS_EXPIRED = 3'd4;
    localparam logic [2:0] STS_NONE    = 3'd5;

    // register indexes (byte address bits 4:3)
    localparam logic [1:0] REG_TIMER_COUNT = 2'd0;
    localparam logic [1:0] REG_REPEAT_MASK = 2'd1;
    localparam logic [1:0] REG_PRIORITY    = 2'd2;

    // input word
    typedef struct packed {
        logic [1:0]     opcode;
        logic [IDW-1:0] timer_index;
        logic [IVW-1:0] interval;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [2:0]     status;
        logic [IDW-1:0] fired_index;
        logic           last;
    } out_word_t;

    // one queue cell entry
    typedef struct packed {
        logic           valid;
        logic [IDW-1:0] id;
        logic [DLW-1:0] deadline;
    } entry_t;

    // key broadcast to all cells
    typedef struct packed {
        logic [IDW-1:0] id;
        logic [DLW-1:0] deadline;
        logic [PRW-1:0] prio;
    } key_t;

    // cell command
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_POP    = 2'd3
    } cell_cmd_t;

    // priority of a timer from the packed priority register
    function automatic logic [PRW-1:0] prio_of(input logic [63:0] prio_bits,
                                               input logic [IDW-1:0] id);
        return prio_bits[{id, 3'b000} +: PRW];
    endfunction

endpackage

### rtl/core/sorted_multi_timer_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_multi_timer_queue_core
// Timer queue sorted by deadline, then priority, then arrival, held in a
// row of cells; handles tick, start and stop commands.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload              notes
//  command   start / busy          item   (in_word_t)   taken when start && !busy
//  result    done (one cycle)      result (out_word_t)  no back-pressure
//  config    psel/penable/pwrite   paddr, pwdata        64-bit regs at 8*i
//
//  stop, refused and bad-id commands finish in idle; start adds the deadline,
//  then the cells insert in parallel.
//  tick pops the expired heads one per cycle, then shows one result per fired
//  timer, with one more step for each repeated timer reinserted.
//  reset empties the queue at once, time starts at zero; no clearing pass.
//  results are shown for one cycle each and cannot be stalled.
//
module sorted_multi_timer_queue_core #(
    parameter int MAX_TIMERS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  smtq_pkg::in_word_t  item,
    output logic                done,
    output smtq_pkg::out_word_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam logic [3:0] MAX_CNT = 4'(MAX_TIMERS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_INSERT = 5'b00010,
        S_POP    = 5'b00100,
        S_LOAD   = 5'b01000,
        S_REINS  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [smtq_pkg::DLW-1:0]        time_now_reg, time_now_next;
    logic [smtq_pkg::IVW-1:0]        interval_reg [MAX_TIMERS];
    logic [smtq_pkg::IVW-1:0]        interval_next [MAX_TIMERS];
    logic [smtq_pkg::IDW-1:0]        fired_reg [MAX_TIMERS];
    logic [smtq_pkg::IDW-1:0]        fired_next [MAX_TIMERS];
    logic [CW-1:0]                   fire_cnt_reg, fire_cnt_next;
    logic [IW-1:0]                   fire_ptr_reg, fire_ptr_next;
    logic [smtq_pkg::IDW-1:0]        ins_id_reg, ins_id_next;
    logic [smtq_pkg::DLW-1:0]        ins_dl_reg, ins_dl_next;
    logic [3:0]                      timer_count_reg, timer_count_next;
    logic [7:0]                      repeat_mask_reg, repeat_mask_next;
    logic [63:0]                     prio_bits_reg, prio_bits_next;
    logic                            done_reg, done_next;
    smtq_pkg::out_word_t             result_reg, result_next;

    smtq_pkg::cell_cmd_t             cell_cmd;
    smtq_pkg::key_t                  key;
    smtq_pkg::entry_t                entries  [MAX_TIMERS];
    smtq_pkg::entry_t                left_in  [MAX_TIMERS];
    smtq_pkg::entry_t                right_in [MAX_TIMERS];
    logic                            found [MAX_TIMERS+1];

    logic [3:0]                      limit;
    logic                            id_bad;
    logic                            running;
    logic                            head_expired;
    logic                            tail_free;
    logic [smtq_pkg::IDW-1:0]        cur_fire;
    logic                            last_fire;
    logic                            cfg_write;

    // broadcast key: addressed id while idle, pending insert otherwise
    assign key.id       = (state_reg == S_IDLE) ? item.timer_index : ins_id_reg;
    assign key.deadline = ins_dl_reg;
    assign key.prio     = smtq_pkg::prio_of(prio_bits_reg, key.id);

    // row of cells
    assign found[0] = 1'b0;
    for (genvar g = 0; g < MAX_TIMERS; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign left_in[g] = '0;
        end
        else
        begin : g_inner_l
            assign left_in[g] = entries[g-1];
        end
        if (g == MAX_TIMERS - 1)
        begin : g_last
            assign right_in[g] = '0;
        end
        else
        begin : g_inner_r
            assign right_in[g] = entries[g+1];
        end

        smtq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cell_cmd),
            .key       (key),
            .prio_bits (prio_bits_reg),
            .left      (left_in[g]),
            .right     (right_in[g]),
            .found_in  (found[g]),
            .found_out (found[g+1]),
            .entry     (entries[g])
        );
    end

    // queue status
    assign running      = found[MAX_TIMERS];
    assign head_expired = entries[0].valid && (entries[0].deadline <= time_now_reg);
    assign tail_free    = !entries[MAX_TIMERS-1].valid;
    assign limit        = (timer_count_reg > MAX_CNT) ? MAX_CNT : timer_count_reg;
    assign id_bad       = ({1'b0, item.timer_index} >= limit);
    assign cur_fire     = fired_reg[fire_ptr_reg];
    assign last_fire    = ((CW'(fire_ptr_reg) + CW'(1)) == fire_cnt_reg);
    assign cfg_write    = psel && penable && pwrite;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        time_now_next    = time_now_reg;
        interval_next    = interval_reg;
        fired_next       = fired_reg;
        fire_cnt_next    = fire_cnt_reg;
        fire_ptr_next    = fire_ptr_reg;
        ins_id_next      = ins_id_reg;
        ins_dl_next      = ins_dl_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        cell_cmd         = smtq_pkg::CELL_HOLD;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    result_next.fired_index = item.timer_index;
                    result_next.last        = 1'b1;
                    if (item.opcode == smtq_pkg::OP_TICK)
                    begin
                        time_now_next = time_now_reg + 64'd1;
                        fire_cnt_next = '0;
                        state_next    = S_POP;
                    end
                    else if ((item.opcode == smtq_pkg::OP_START) && !id_bad)
                    begin
                        done_next = 1'b1;
                        if (running)
                        begin
                            result_next.status = smtq_pkg::STS_REFUSED;
                        end
                        else
                        begin
                            result_next.status = smtq_pkg::STS_STARTED;
                            interval_next[item.timer_index[IW-1:0]] = item.interval;
                            ins_id_next = item.timer_index;
                            ins_dl_next = time_now_reg + {32'd0, item.interval};
                            state_next  = S_INSERT;
                        end
                    end
                    else if ((item.opcode == smtq_pkg::OP_STOP) && !id_bad)
                    begin
                        // unlink is a no-op when no cell matches
                        done_next          = 1'b1;
                        result_next.status = smtq_pkg::STS_STOPPED;
                        cell_cmd           = smtq_pkg::CELL_REMOVE;
                    end
                    else
                    begin
                        done_next          = 1'b1;
                        result_next.status = smtq_pkg::STS_BAD_ID;
                    end
                end
            end
            S_INSERT:
            begin
                if (tail_free)
                begin
                    cell_cmd = smtq_pkg::CELL_INSERT;
                end
                state_next = S_IDLE;
            end
            S_POP:
            begin
                if (head_expired)
                begin
                    cell_cmd = smtq_pkg::CELL_POP;
                    fired_next[fire_cnt_reg[IW-1:0]] = entries[0].id;
                    fire_cnt_next = fire_cnt_reg + CW'(1);
                end
                else if (fire_cnt_reg == '0)
                begin
                    done_next               = 1'b1;
                    result_next.status      = smtq_pkg::STS_NONE;
                    result_next.fired_index = '0;
                    result_next.last        = 1'b1;
                    state_next              = S_IDLE;
                end
                else
                begin
                    fire_ptr_next = '0;
                    state_next    = S_LOAD;
                end
            end
            S_LOAD:
            begin
                done_next               = 1'b1;
                result_next.status      = smtq_pkg::STS_EXPIRED;
                result_next.fired_index = cur_fire;
                result_next.last        = last_fire;
                if (repeat_mask_reg[cur_fire])
                begin
                    ins_id_next = cur_fire;
                    ins_dl_next = time_now_reg + {32'd0, interval_reg[cur_fire[IW-1:0]]};
                    state_next  = S_REINS;
                end
                else if (last_fire)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    fire_ptr_next = fire_ptr_reg + IW'(1);
                end
            end
            S_REINS:
            begin
                if (tail_free)
                begin
                    cell_cmd = smtq_pkg::CELL_INSERT;
                end
                if (last_fire)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    fire_ptr_next = fire_ptr_reg + IW'(1);
                    state_next    = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        timer_count_next = timer_count_reg;
        repeat_mask_next = repeat_mask_reg;
        prio_bits_next   = prio_bits_reg;
        if (cfg_write)
        begin
            unique case (paddr[4:3])
                smtq_pkg::REG_TIMER_COUNT: timer_count_next = pwdata[3:0];
                smtq_pkg::REG_REPEAT_MASK: repeat_mask_next = pwdata[7:0];
                smtq_pkg::REG_PRIORITY:    prio_bits_next   = pwdata;
                default:
                begin
                end
            endcase
        end
    end

    // configuration reads
    always_comb
    begin
        unique case (paddr[4:3])
            smtq_pkg::REG_TIMER_COUNT: prdata = {60'd0, timer_count_reg};
            smtq_pkg::REG_REPEAT_MASK: prdata = {56'd0, repeat_mask_reg};
            smtq_pkg::REG_PRIORITY:    prdata = prio_bits_reg;
            default:                   prdata = 64'd0;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            time_now_reg    <= '0;
            fire_cnt_reg    <= '0;
            fire_ptr_reg    <= '0;
            timer_count_reg <= '0;
            repeat_mask_reg <= '0;
            prio_bits_reg   <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            time_now_reg    <= time_now_next;
            fire_cnt_reg    <= fire_cnt_next;
            fire_ptr_reg    <= fire_ptr_next;
            timer_count_reg <= timer_count_next;
            repeat_mask_reg <= repeat_mask_next;
            prio_bits_reg   <= prio_bits_next;
            done_reg        <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        interval_reg <= interval_next;
        fired_reg    <= fired_next;
        ins_id_reg   <= ins_id_next;
        ins_dl_reg   <= ins_dl_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign pready = 1'b1;

endmodule

### rtl/core/smtq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smtq_cell
// One slot of the sorted queue: holds an entry, compares it with the
// broadcast key and shifts with its neighbors on insert, remove and pop.
// ----------------------------------------------------------------------------
module smtq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  smtq_pkg::cell_cmd_t cmd,
    input  smtq_pkg::key_t      key,
    input  logic [63:0]         prio_bits,
    input  smtq_pkg::entry_t    left,
    input  smtq_pkg::entry_t    right,
    input  logic                found_in,
    output logic                found_out,
    output smtq_pkg::entry_t    entry
);

    logic                          valid_reg, valid_next;
    logic [smtq_pkg::IDW-1:0]      id_reg, id_next;
    logic [smtq_pkg::DLW-1:0]      deadline_reg, deadline_next;
    logic [smtq_pkg::PRW-1:0]      own_prio;
    logic                          before_me;
    logic                          match;
    logic                          hit;

    // ordering: new key goes ahead of this entry
    assign own_prio  = smtq_pkg::prio_of(prio_bits, id_reg);
    assign before_me = !valid_reg || (deadline_reg > key.deadline) ||
                       ((deadline_reg == key.deadline) && (own_prio < key.prio));
    assign match     = valid_reg && (id_reg == key.id);

    // hit chain: insertion point or id match, first cell wins
    assign hit       = (cmd == smtq_pkg::CELL_INSERT) ? before_me : match;
    assign found_out = found_in | hit;

    // next entry
    always_comb
    begin
        valid_next    = valid_reg;
        id_next       = id_reg;
        deadline_next = deadline_reg;
        unique case (cmd)
            smtq_pkg::CELL_HOLD:
            begin
            end
            smtq_pkg::CELL_INSERT:
            begin
                if (found_in)
                begin
                    valid_next    = left.valid;
                    id_next       = left.id;
                    deadline_next = left.deadline;
                end
                else if (before_me)
                begin
                    valid_next    = 1'b1;
                    id_next       = key.id;
                    deadline_next = key.deadline;
                end
            end
            smtq_pkg::CELL_REMOVE:
            begin
                if (found_out)
                begin
                    valid_next    = right.valid;
                    id_next       = right.id;
                    deadline_next = right.deadline;
                end
            end
            smtq_pkg::CELL_POP:
            begin
                valid_next    = right.valid;
                id_next       = right.id;
                deadline_next = right.deadline;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        deadline_reg <= deadline_next;
    end

    assign entry.valid    = valid_reg;
    assign entry.id       = id_reg;
    assign entry.deadline = deadline_reg;

endmodule

### dv/tb_sorted_multi_timer_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_multi_timer_queue_core
// Self-checking bench for the deadline-sorted timer queue. A directed table
// covers the register extremes, the error codes, ordering by deadline,
// priority and arrival, multiple expiry in one tick, repeated timers and
// stop at the head of the queue. Random command bursts follow under several
// register settings. Every result word is checked against a typed table word
// or a software copy of the queue kept in step with each accepted command word.
// ----------------------------------------------------------------------------
module tb_sorted_multi_timer_queue_core;

    localparam logic [1:0] OP_UNDEF      = 2'd3;
    localparam int         QUEUE_DEPTH   = 8;
    localparam int         SETTLE_CYCLES = 2 + 3 * QUEUE_DEPTH + 4;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         NUM_PHASES    = 7;
    localparam int         PHASE_ITEMS   = 50;
    localparam int         REPORT_LIMIT  = 10;

    // one row of the directed table: a register write or a command word
    typedef struct {
        bit                  is_reg;
        logic [1:0]          reg_sel;
        logic [63:0]         reg_val;
        smtq_pkg::in_word_t  word;
        bit                  typed;
        smtq_pkg::out_word_t typed_word;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    smtq_pkg::in_word_t  item;
    logic                done;
    smtq_pkg::out_word_t result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [4:0]          paddr;
    logic [63:0]         pwdata;
    logic [63:0]         prdata;
    logic                pready;

    // software copy of the queue and its registers
    logic [3:0]  cnt_reg;
    logic [7:0]  rep_reg;
    logic [63:0] pri_reg;
    logic [63:0] now_q;
    logic [63:0] dl_q [QUEUE_DEPTH];
    logic [31:0] ivl_q [QUEUE_DEPTH];
    logic        run_q [QUEUE_DEPTH];
    logic [2:0]  slot_q [QUEUE_DEPTH];
    int unsigned qlen;

    smtq_pkg::out_word_t step_words [$];
    smtq_pkg::out_word_t awaited_status [$];
    stim_row_t           directed_rows [$];

    bit                  cur_typed;
    smtq_pkg::out_word_t cur_typed_word;
    int unsigned         failure_count;
    int unsigned         cycle_count;

    sorted_multi_timer_queue_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock, 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // cycle counter and watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    function automatic smtq_pkg::out_word_t make_word(input logic [2:0] st,
                                                      input logic [2:0] idx,
                                                      input logic lst);
        smtq_pkg::out_word_t w;
        w.status      = st;
        w.fired_index = idx;
        w.last        = lst;
        return w;
    endfunction

    function automatic logic [7:0] timer_prio(input logic [2:0] id);
        return pri_reg[int'(id) * 8 +: 8];
    endfunction

    // sorted insert: later deadline, or equal deadline with lower priority, goes behind
    function automatic void insert_timer(input logic [2:0] id);
        int unsigned pos;
        int unsigned i;
        bit          found;
        logic [63:0] d;
        logic [7:0]  p;
        d     = dl_q[id];
        p     = timer_prio(id);
        found = 1'b0;
        if (qlen < QUEUE_DEPTH)
        begin
            pos = qlen;
            for (i = 0; i < qlen; i++)
            begin
                if (!found && (dl_q[slot_q[i]] > d ||
                               (dl_q[slot_q[i]] == d && timer_prio(slot_q[i]) < p)))
                begin
                    pos   = i;
                    found = 1'b1;
                end
            end
            for (i = qlen; i > pos; i--)
                slot_q[i] = slot_q[i - 1];
            slot_q[pos] = id;
            qlen++;
            run_q[id] = 1'b1;
        end
    endfunction

    // result words caused by one accepted command word
    function automatic void predict_timer_op(input smtq_pkg::in_word_t w);
        logic [2:0]  fired [QUEUE_DEPTH];
        int unsigned n;
        int unsigned k;
        int unsigned lim;
        logic [2:0]  id;
        bit          gone;
        step_words.delete();
        id  = w.timer_index;
        lim = (cnt_reg > 4'd8) ? 8 : cnt_reg;
        if (w.opcode == smtq_pkg::OP_TICK)
        begin
            now_q = now_q + 64'd1;
            n     = 0;
            while (n < qlen && dl_q[slot_q[n]] <= now_q)
            begin
                fired[n] = slot_q[n];
                n++;
            end
            if (n == 0)
                step_words.push_back(make_word(smtq_pkg::STS_NONE, 3'd0, 1'b1));
            else
            begin
                for (k = 0; k + n < qlen; k++)
                    slot_q[k] = slot_q[k + n];
                qlen = qlen - n;
                for (k = 0; k < n; k++)
                    run_q[fired[k]] = 1'b0;
                // repeated timers go back in firing order
                for (k = 0; k < n; k++)
                begin
                    if (rep_reg[fired[k]])
                    begin
                        dl_q[fired[k]] = now_q + {32'd0, ivl_q[fired[k]]};
                        insert_timer(fired[k]);
                    end
                    step_words.push_back(make_word(smtq_pkg::STS_EXPIRED, fired[k],
                                                   k + 1 == n));
                end
            end
        end
        else if (w.opcode == OP_UNDEF || id >= lim)
            step_words.push_back(make_word(smtq_pkg::STS_BAD_ID, id, 1'b1));
        else if (w.opcode == smtq_pkg::OP_START)
        begin
            if (run_q[id])
                step_words.push_back(make_word(smtq_pkg::STS_REFUSED, id, 1'b1));
            else
            begin
                ivl_q[id] = w.interval;
                dl_q[id]  = now_q + {32'd0, w.interval};
                insert_timer(id);
                step_words.push_back(make_word(smtq_pkg::STS_STARTED, id, 1'b1));
            end
        end
        else
        begin
            // stop unlinks wherever the timer stands
            if (run_q[id])
            begin
                gone = 1'b0;
                for (k = 0; k < qlen; k++)
                begin
                    if (!gone && slot_q[k] == id)
                        gone = 1'b1;
                    if (gone && k + 1 < qlen)
                        slot_q[k] = slot_q[k + 1];
                end
                if (gone)
                    qlen--;
                run_q[id] = 1'b0;
            end
            step_words.push_back(make_word(smtq_pkg::STS_STOPPED, id, 1'b1));
        end
    endfunction

    function automatic void note_failure(input string msg);
        failure_count++;
        if (failure_count <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    // result check and prediction on every accepted word
    always @(posedge clk)
    begin : result_check
        smtq_pkg::out_word_t want;
        if (rst_n && done)
        begin
            if (awaited_status.size() == 0)
                note_failure($sformatf("unexpected result: status %0d index %0d last %0d",
                                       result.status, result.fired_index, result.last));
            else
            begin
                want = awaited_status.pop_front();
                if (result.status !== want.status || result.fired_index !== want.fired_index ||
                    result.last !== want.last)
                    note_failure($sformatf(
                        "result mismatch: exp status %0d index %0d last %0d, got %0d %0d %0d",
                        want.status, want.fired_index, want.last,
                        result.status, result.fired_index, result.last));
            end
        end
        if (rst_n && start && !busy)
        begin
            predict_timer_op(item);
            if (cur_typed)
                awaited_status.push_back(cur_typed_word);
            else
                foreach (step_words[i])
                    awaited_status.push_back(step_words[i]);
        end
    end

    function automatic void add_cmd(input logic [1:0] op, input logic [2:0] idx,
                                    input logic [31:0] ivl, input bit typed,
                                    input logic [2:0] st);
        stim_row_t r;
        r.is_reg             = 1'b0;
        r.reg_sel            = smtq_pkg::REG_TIMER_COUNT;
        r.reg_val            = 64'd0;
        r.word.opcode        = op;
        r.word.timer_index   = idx;
        r.word.interval      = ivl;
        r.typed              = typed;
        r.typed_word         = make_word(st, idx, 1'b1);
        directed_rows.push_back(r);
    endfunction

    function automatic void add_reg(input logic [1:0] sel, input logic [63:0] val);
        stim_row_t r;
        r.is_reg     = 1'b1;
        r.reg_sel    = sel;
        r.reg_val    = val;
        r.word       = '0;
        r.typed      = 1'b0;
        r.typed_word = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic smtq_pkg::in_word_t pick_command();
        smtq_pkg::in_word_t w;
        int unsigned        r;
        int unsigned        lim;
        lim           = (cnt_reg > 4'd8) ? 8 : cnt_reg;
        w.interval    = $urandom;
        w.timer_index = $urandom_range(0, 7);
        r             = $urandom_range(0, 99);
        if (r < 42)
            w.opcode = smtq_pkg::OP_TICK;
        else if (r < 80)
        begin
            w.opcode = smtq_pkg::OP_START;
            // mostly short timeouts so that timers actually fire
            r = $urandom_range(0, 19);
            if (r < 12)
                w.interval = $urandom_range(0, 6);
            else if (r < 17)
                w.interval = $urandom_range(0, 40);
            else if (r == 19)
                w.interval = 32'hFFFF_FFFF;
        end
        else if (r < 96)
            w.opcode = smtq_pkg::OP_STOP;
        else
            w.opcode = OP_UNDEF;
        if (w.opcode != smtq_pkg::OP_TICK && lim > 0 && $urandom_range(0, 9) < 8)
            w.timer_index = $urandom_range(0, lim - 1);
        return w;
    endfunction

    // present one word from a falling edge until it is taken
    task automatic send_word(input smtq_pkg::in_word_t w, input bit typed,
                             input smtq_pkg::out_word_t tw);
        bit taken;
        item           = w;
        cur_typed      = typed;
        cur_typed_word = tw;
        start          = 1'b1;
        do
        begin
            @(posedge clk);
            taken = !busy;
            @(negedge clk);
        end
        while (!taken);
    endtask

    // apb write, setup then access
    task automatic write_reg(input logic [1:0] sel, input logic [63:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 3'b000};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (sel)
            smtq_pkg::REG_TIMER_COUNT: cnt_reg = val[3:0];
            smtq_pkg::REG_REPEAT_MASK: rep_reg = val[7:0];
            smtq_pkg::REG_PRIORITY:    pri_reg = val;
            default:                   ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // wait for all results, then let reinsertion finish
    task automatic wait_queue_quiet();
        while (awaited_status.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int unsigned burst_left;
        int unsigned gap;
        cycle_count   = 0;
        failure_count = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        item          = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cur_typed     = 1'b0;
        cur_typed_word = '0;
        cnt_reg       = '0;
        rep_reg       = '0;
        pri_reg       = '0;
        now_q         = '0;
        qlen          = 0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            dl_q[i]   = '0;
            ivl_q[i]  = '0;
            run_q[i]  = 1'b0;
            slot_q[i] = '0;
        end

        // directed table
        add_cmd(smtq_pkg::OP_TICK,  3'd0, 32'd0,         1, smtq_pkg::STS_NONE);
        add_cmd(smtq_pkg::OP_START, 3'd0, 32'd5,         1, smtq_pkg::STS_BAD_ID);
        add_cmd(OP_UNDEF,           3'd7, 32'hFFFF_FFFF, 1, smtq_pkg::STS_BAD_ID);
        add_reg(smtq_pkg::REG_TIMER_COUNT, 64'd8);
        add_reg(smtq_pkg::REG_REPEAT_MASK, 64'h05);
        add_reg(smtq_pkg::REG_PRIORITY,    64'hFF10_1080_0010_FF10);
        add_cmd(smtq_pkg::OP_START, 3'd0, 32'd0,         1, smtq_pkg::STS_STARTED);
        add_cmd(smtq_pkg::OP_START, 3'd0, 32'd3,         1, smtq_pkg::STS_REFUSED);
        add_cmd(smtq_pkg::OP_START, 3'd1, 32'd2,         0, smtq_pkg::STS_STARTED);
        add_cmd(smtq_pkg::OP_START, 3'd3, 32'd2,         0, smtq_pkg::STS_STARTED);
        add_cmd(smtq_pkg::OP_START, 3'd5, 32'd2,         0, smtq_pkg::STS_STARTED);
        add_cmd(smtq_pkg::OP_START, 3'd6, 32'd2,         0, smtq_pkg::STS_STARTED);
        add_cmd(smtq_pkg::OP_START, 3'd2, 32'd1,         0, smtq_pkg::STS_STARTED);
        add_cmd(smtq_pkg::OP_TICK,  3'd7, 32'hFFFF_FFFF, 0, smtq_pkg::STS_NONE);
        add_cmd(smtq_pkg::OP_TICK,  3'd0, 32'd0,         0, smtq_pkg::STS_NONE);
        add_cmd(smtq_pkg::OP_START, 3'd4, 32'hFFFF_FFFF, 0, smtq_pkg::STS_STARTED);
        add_cmd(smtq_pkg::OP_STOP,  3'd4, 32'd0,         1, smtq_pkg::STS_STOPPED);
        add_cmd(smtq_pkg::OP_STOP,  3'd4, 32'hA5A5_5A5A, 1, smtq_pkg::STS_STOPPED);
        add_cmd(smtq_pkg::OP_START, 3'd7, 32'd1,         0, smtq_pkg::STS_STARTED);
        add_cmd(smtq_pkg::OP_STOP,  3'd0, 32'd0,         1, smtq_pkg::STS_STOPPED);
        add_cmd(smtq_pkg::OP_STOP,  3'd2, 32'd0,         1, smtq_pkg::STS_STOPPED);
        add_reg(smtq_pkg::REG_TIMER_COUNT, 64'd2);
        add_cmd(smtq_pkg::OP_START, 3'd7, 32'd9,         1, smtq_pkg::STS_BAD_ID);
        add_cmd(smtq_pkg::OP_STOP,  3'd7, 32'd0,         1, smtq_pkg::STS_BAD_ID);
        add_cmd(smtq_pkg::OP_TICK,  3'd0, 32'd0,         0, smtq_pkg::STS_NONE);
        add_cmd(smtq_pkg::OP_START, 3'd1, 32'd0,         1, smtq_pkg::STS_STARTED);
        add_cmd(smtq_pkg::OP_TICK,  3'd0, 32'd0,         0, smtq_pkg::STS_NONE);
        add_reg(smtq_pkg::REG_TIMER_COUNT, 64'd15);
        add_cmd(smtq_pkg::OP_START, 3'd7, 32'd0,         1, smtq_pkg::STS_STARTED);
        add_cmd(smtq_pkg::OP_TICK,  3'd5, 32'h5A5A_A5A5, 0, smtq_pkg::STS_NONE);

        // hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_reg)
            begin
                start = 1'b0;
                wait_queue_quiet();
                write_reg(directed_rows[r].reg_sel, directed_rows[r].reg_val);
            end
            else
                send_word(directed_rows[r].word, directed_rows[r].typed,
                          directed_rows[r].typed_word);
        end

        // random bursts under several register settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            start = 1'b0;
            wait_queue_quiet();
            case (ph)
                0:
                begin
                    write_reg(smtq_pkg::REG_TIMER_COUNT, 64'd8);
                    write_reg(smtq_pkg::REG_REPEAT_MASK, 64'hFF);
                    write_reg(smtq_pkg::REG_PRIORITY,    64'd0);
                end
                1:
                begin
                    write_reg(smtq_pkg::REG_TIMER_COUNT, 64'd8);
                    write_reg(smtq_pkg::REG_REPEAT_MASK, {56'd0, 8'($urandom)});
                    write_reg(smtq_pkg::REG_PRIORITY,    {$urandom, $urandom});
                end
                2:
                begin
                    write_reg(smtq_pkg::REG_TIMER_COUNT, 64'd3);
                    write_reg(smtq_pkg::REG_REPEAT_MASK, 64'h00);
                    write_reg(smtq_pkg::REG_PRIORITY,    64'hFFFF_FFFF_FFFF_FFFF);
                end
                3:
                begin
                    write_reg(smtq_pkg::REG_TIMER_COUNT, 64'd15);
                    write_reg(smtq_pkg::REG_REPEAT_MASK, {56'd0, 8'($urandom)});
                    write_reg(smtq_pkg::REG_PRIORITY,    {$urandom, $urandom});
                end
                4:
                begin
                    // timers already running keep firing with no valid ids
                    write_reg(smtq_pkg::REG_TIMER_COUNT, 64'd0);
                    write_reg(smtq_pkg::REG_REPEAT_MASK, {56'd0, 8'($urandom)});
                    write_reg(smtq_pkg::REG_PRIORITY,    {$urandom, $urandom});
                end
                5:
                begin
                    write_reg(smtq_pkg::REG_TIMER_COUNT, 64'd1);
                    write_reg(smtq_pkg::REG_REPEAT_MASK, 64'hFF);
                    write_reg(smtq_pkg::REG_PRIORITY,    {$urandom, $urandom});
                end
                default:
                begin
                    write_reg(smtq_pkg::REG_TIMER_COUNT, 64'($urandom_range(2, 8)));
                    write_reg(smtq_pkg::REG_REPEAT_MASK, {56'd0, 8'($urandom)});
                    write_reg(smtq_pkg::REG_PRIORITY,    {$urandom, $urandom});
                end
            endcase
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        // hold off until every result is in
                        start = 1'b0;
                        wait_queue_quiet();
                    end
                    else
                    begin
                        gap = $urandom_range(0, 6);
                        if (gap > 0)
                        begin
                            start = 1'b0;
                            repeat (gap) @(negedge clk);
                        end
                    end
                    burst_left = $urandom_range(1, 20);
                end
                send_word(pick_command(), 1'b0, '0);
                burst_left--;
            end
        end

        // drain and report
        start = 1'b0;
        wait_queue_quiet();
        if (failure_count == 0 && awaited_status.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sorted_multi_timer_queue_core.f
rtl/core/smtq_pkg.sv
rtl/core/smtq_cell.sv
rtl/core/sorted_multi_timer_queue_core.sv
dv/tb_sorted_multi_timer_queue_core.sv
